/* design/degree_sine_cosine_macros.svh */
// ----------------------------------------------------------------------------
// degree_sine_cosine assertion macros
// Shared concurrent assertion forms, clocked on i_clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef DEGREE_SINE_COSINE_MACROS_SVH
`define DEGREE_SINE_COSINE_MACROS_SVH

// Same-cycle implication.
`define DSC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dsc_pkg.sv */
// ----------------------------------------------------------------------------
// dsc_pkg
// Types, constants and the arctangent table of the degree sine/cosine block.
// ----------------------------------------------------------------------------
package dsc_pkg;

    // Default number of rotation stages.
    localparam int DSC_STEPS_DEFAULT = 16;

    // Widths of the item fields.
    localparam int DSC_ANGLE_W = 32;
    localparam int DSC_OUT_W   = 18;
    localparam int DSC_IN_TDATA_W  = 32;
    localparam int DSC_OUT_TDATA_W = 40;

    // 92 full turns: makes every signed angle positive, keeps the residue.
    localparam logic [32:0] DSC_OFFSET = 33'd2170552320;
    // A full turn is 45 * 2^19; floor(2^20 / 45) estimates the quotient.
    localparam logic [28:0] DSC_RECIP  = 29'd23301;
    localparam logic [13:0] DSC_MOD_DIV = 14'd45;
    localparam logic [6:0]  DSC_MOD_DIV7 = 7'd45;
    localparam logic [24:0] DSC_QUARTER = 25'd5898240;

    // Starting x: reciprocal of the limit of the rotation gain in Q2.30.
    localparam logic signed [31:0] DSC_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [32:0] DSC_ROUND_HALF = 33'sd8192;
    localparam logic signed [32:0] DSC_ONE_Q16 = 33'sd65536;

    // Quadrant codes.
    localparam logic [1:0] DSC_QUAD_0 = 2'd0;
    localparam logic [1:0] DSC_QUAD_1 = 2'd1;
    localparam logic [1:0] DSC_QUAD_2 = 2'd2;
    localparam logic [1:0] DSC_QUAD_3 = 2'd3;

    // atan(2^-i) in degrees, scaled by 2^24.
    localparam int DSC_ATAN_N = 31;
    localparam logic signed [31:0] DSC_ATAN [DSC_ATAN_N] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115,
        32'sd57,        32'sd29,        32'sd14,        32'sd7,
        32'sd4,         32'sd2,         32'sd1
    };

    // Vector and residual angle carried through the rotation stages.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         quad;
    } t_dsc_rot;

endpackage

/* design/dsc_reduce.sv */
// ----------------------------------------------------------------------------
// dsc_reduce
// Four-stage reduction of the angle modulo 360 degrees and quadrant split.
// ----------------------------------------------------------------------------
module dsc_reduce
    import dsc_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [DSC_ANGLE_W-1:0] i_angle,
    output logic                          o_valid,
    output t_dsc_rot                      o_rot
);

    logic        r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic [13:0] r_s1_hi, r_s2_hi;
    logic [18:0] r_s1_lo, r_s2_lo;
    logic [8:0]  r_s2_q;
    logic [24:0] r_s3_red;
    logic [1:0]  r_s4_quad;
    logic [22:0] r_s4_res;

    logic [32:0] n_u;
    logic [28:0] n_prod;
    logic [13:0] n_q45;
    logic [6:0]  n_r;
    logic [5:0]  n_rem;
    logic [1:0]  n_quad;
    logic [24:0] n_res;

    // Offset the angle by whole turns so that it is positive.
    assign n_u = {i_angle[DSC_ANGLE_W-1], i_angle} + DSC_OFFSET;

    // Estimate the quotient of the upper part by 45.
    assign n_prod = 29'(r_s1_hi) * DSC_RECIP;

    // Remainder of the upper part, with one correction step.
    always_comb begin
        n_q45 = 14'({5'd0, r_s2_q} * DSC_MOD_DIV);
        n_r   = 7'(r_s2_hi - n_q45);
        if (n_r >= DSC_MOD_DIV7) begin
            n_rem = 6'(n_r - DSC_MOD_DIV7);
        end else begin
            n_rem = 6'(n_r);
        end
    end

    // Split off the quadrant from the reduced angle.
    always_comb begin
        if (r_s3_red >= 25'(DSC_QUARTER * 3)) begin
            n_quad = DSC_QUAD_3;
            n_res  = r_s3_red - 25'(DSC_QUARTER * 3);
        end else if (r_s3_red >= 25'(DSC_QUARTER * 2)) begin
            n_quad = DSC_QUAD_2;
            n_res  = r_s3_red - 25'(DSC_QUARTER * 2);
        end else if (r_s3_red >= DSC_QUARTER) begin
            n_quad = DSC_QUAD_1;
            n_res  = r_s3_red - DSC_QUARTER;
        end else begin
            n_quad = DSC_QUAD_0;
            n_res  = r_s3_red;
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    // Data stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_hi   <= n_u[32:19];
            r_s1_lo   <= n_u[18:0];
            r_s2_q    <= n_prod[28:20];
            r_s2_hi   <= r_s1_hi;
            r_s2_lo   <= r_s1_lo;
            r_s3_red  <= {n_rem, r_s2_lo};
            r_s4_quad <= n_quad;
            r_s4_res  <= n_res[22:0];
        end
    end

    assign o_valid    = r_s4_valid;
    assign o_rot.x    = DSC_GAIN_Q30;
    assign o_rot.y    = '0;
    assign o_rot.z    = $signed({1'b0, r_s4_res, 8'd0});
    assign o_rot.quad = r_s4_quad;

endmodule

/* design/dsc_rot_stage.sv */
// ----------------------------------------------------------------------------
// dsc_rot_stage
// One registered CORDIC rotation toward zero residual angle.
// ----------------------------------------------------------------------------
module dsc_rot_stage
    import dsc_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_dsc_rot i_rot,
    output logic     o_valid,
    output t_dsc_rot o_rot
);

    logic     r_valid;
    t_dsc_rot r_rot;
    t_dsc_rot n_rot;
    logic signed [31:0] n_dx, n_dy;

    // Rotate by the table angle in the direction that shrinks the residue.
    always_comb begin
        n_dx = i_rot.y >>> STAGE;
        n_dy = i_rot.x >>> STAGE;
        n_rot.quad = i_rot.quad;
        if (!i_rot.z[31]) begin
            n_rot.x = i_rot.x - n_dx;
            n_rot.y = i_rot.y + n_dy;
            n_rot.z = i_rot.z - DSC_ATAN[STAGE];
        end else begin
            n_rot.x = i_rot.x + n_dx;
            n_rot.y = i_rot.y - n_dy;
            n_rot.z = i_rot.z + DSC_ATAN[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;

endmodule

/* design/dsc_post.sv */
// ----------------------------------------------------------------------------
// dsc_post
// Rounds the rotated vector to Q1.16, clamps it and maps it to its quadrant.
// ----------------------------------------------------------------------------
module dsc_post
    import dsc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  t_dsc_rot                    i_rot,
    output logic                        o_valid,
    output logic signed [DSC_OUT_W-1:0] o_sine,
    output logic signed [DSC_OUT_W-1:0] o_cosine
);

    // Round half up from Q2.30 to Q1.16 and clamp to plus or minus one.
    function automatic logic signed [DSC_OUT_W-1:0] round_q16(
        input logic signed [31:0] v
    );
        logic signed [32:0] t;
        begin
            t = ($signed({v[31], v}) + DSC_ROUND_HALF) >>> 14;
            if (t > DSC_ONE_Q16) begin
                t = DSC_ONE_Q16;
            end else if (t < -DSC_ONE_Q16) begin
                t = -DSC_ONE_Q16;
            end
            round_q16 = t[DSC_OUT_W-1:0];
        end
    endfunction

    logic                        r_rnd_valid, r_out_valid;
    logic signed [DSC_OUT_W-1:0] r_s, r_c, r_sine, r_cosine;
    logic [1:0]                  r_quad;
    logic signed [DSC_OUT_W-1:0] n_sine, n_cosine;

    // Map the first-quadrant pair back to the angle's quadrant.
    always_comb begin
        case (r_quad)
            DSC_QUAD_0: begin
                n_sine   = r_s;
                n_cosine = r_c;
            end
            DSC_QUAD_1: begin
                n_sine   = r_c;
                n_cosine = -r_s;
            end
            DSC_QUAD_2: begin
                n_sine   = -r_s;
                n_cosine = -r_c;
            end
            default: begin
                n_sine   = -r_c;
                n_cosine = r_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_rnd_valid <= i_valid;
            r_out_valid <= r_rnd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s      <= round_q16(i_rot.y);
            r_c      <= round_q16(i_rot.x);
            r_quad   <= i_rot.quad;
            r_sine   <= n_sine;
            r_cosine <= n_cosine;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sine   = r_sine;
    assign o_cosine = r_cosine;

endmodule

/* design/degree_sine_cosine.sv */
// ----------------------------------------------------------------------------
// degree_sine_cosine
// Sine and cosine of an angle in degrees through a pipelined CORDIC.
// ----------------------------------------------------------------------------
// The input channel (i_s_*) takes one angle per item, signed Q16.16 degrees.
// The output channel (o_m_*) returns one item per angle with the sine and
// cosine, each signed Q1.16 and held to the range of plus or minus one.
// Items leave in the order they arrived.
// The pipeline holds the modulo-360 reduction and quadrant split, then a
// rotation stage for each step, a rounding register and an output register.
// Throughput is one item per cycle while the receiver keeps up; every stage
// is a register set that moves on a shared enable.
// After reset all valid bits are clear and the block accepts at once.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_s_tready drops; nothing is lost or repeated, and the flow resumes
// in the cycle the receiver takes the waiting item.
// ----------------------------------------------------------------------------
module degree_sine_cosine
    import dsc_pkg::*;
#(
    parameter int ROTATION_STEPS = DSC_STEPS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [DSC_IN_TDATA_W-1:0]  i_s_tdata,  // [31:0] angle_deg
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [DSC_OUT_TDATA_W-1:0] o_m_tdata   // [17:0] sine, [35:18] cosine
);

    logic                        w_en;
    logic                        w_out_valid;
    logic signed [DSC_OUT_W-1:0] w_sine, w_cosine;
    logic                        w_valid [ROTATION_STEPS+1];
    t_dsc_rot                    w_rot   [ROTATION_STEPS+1];

    // All stages move together unless a result waits on the receiver.
    assign w_en       = !w_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    dsc_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_angle ($signed(i_s_tdata[DSC_ANGLE_W-1:0])),
        .o_valid (w_valid[0]),
        .o_rot   (w_rot[0])
    );

    // One rotation stage per step.
    for (genvar k = 0; k < ROTATION_STEPS; k++) begin : g_rot
        dsc_rot_stage #(
            .STAGE (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_rot   (w_rot[k]),
            .o_valid (w_valid[k+1]),
            .o_rot   (w_rot[k+1])
        );
    end

    dsc_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_valid[ROTATION_STEPS]),
        .i_rot    (w_rot[ROTATION_STEPS]),
        .o_valid  (w_out_valid),
        .o_sine   (w_sine),
        .o_cosine (w_cosine)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = {{(DSC_OUT_TDATA_W - 2*DSC_OUT_W){1'b0}}, w_cosine, w_sine};

endmodule

/* design/dsc_checker.sv */
// ----------------------------------------------------------------------------
// dsc_checker
// Port-level checks of the degree sine/cosine block, bound to its top level.
// ----------------------------------------------------------------------------
`include "degree_sine_cosine_macros.svh"

module dsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] i_m_tdata
);

    logic               w_stall;
    logic               w_range_ok;
    logic signed [17:0] w_sine, w_cosine;

    assign w_stall  = i_m_tvalid && !i_m_tready;
    assign w_sine   = $signed(i_m_tdata[17:0]);
    assign w_cosine = $signed(i_m_tdata[35:18]);
    assign w_range_ok = (w_sine <= 18'sd65536) && (w_sine >= -18'sd65536) &&
                        (w_cosine <= 18'sd65536) && (w_cosine >= -18'sd65536);

    // A stalled result holds its value.
    `DSC_ASSERT_NEXT(a_hold, w_stall, i_m_tvalid && $stable(i_m_tdata), "stalled item changed")

    // The block takes items whenever no result is waiting.
    `DSC_ASSERT_IMPL(a_ready, !i_m_tvalid, i_s_tready, "input not ready with empty output")

    // Both results stay within plus or minus one.
    `DSC_ASSERT_IMPL(a_range, i_m_tvalid, w_range_ok, "result out of range")

    // Padding bits are zero.
    `DSC_ASSERT_IMPL(a_pad, i_m_tvalid, i_m_tdata[39:36] == 4'd0, "padding bits set")

endmodule

bind degree_sine_cosine dsc_checker u_dsc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

/* tb/sv/degree_sine_cosine_checker.sv */
// ----------------------------------------------------------------------------
// degree_sine_cosine_checker
// Watches both channels of the degree sine/cosine block and checks every
// result item against a bit-exact CORDIC prediction of the accepted angle.
// ----------------------------------------------------------------------------
module degree_sine_cosine_checker
    import dsc_pkg::*;
#(
    parameter int ROTATION_STEPS = DSC_STEPS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    input  logic [DSC_IN_TDATA_W-1:0]  i_s_tdata,  // [31:0] angle_deg
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    input  logic [DSC_OUT_TDATA_W-1:0] i_m_tdata,  // [17:0] sine, [35:18] cosine
    output int                         o_fail_count,
    output int                         o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint FULL_TURN_Q16    = 64'sd23592960;
    localparam longint QUARTER_TURN_Q16 = 64'sd5898240;
    localparam longint GAIN_Q30         = 64'sd652032874;
    localparam longint ROUND_HALF_Q30   = 64'sd8192;
    localparam longint UNIT_Q16         = 64'sd65536;
    localparam int     ATAN_COUNT       = 31;

    // Arctangent of 2^-i in degrees, 24 fraction bits.
    localparam longint ATAN_DEG_Q24 [ATAN_COUNT] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
        117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
        115, 57, 29, 14, 7, 4, 2, 1
    };

    typedef struct packed {
        logic signed [DSC_OUT_W-1:0] sine;
        logic signed [DSC_OUT_W-1:0] cosine;
    } trig_pair_t;

    trig_pair_t trig_expected_q [$];

    // Rounds a Q2.30 value half up to Q1.16 and clamps it to plus or minus one.
    function automatic longint round_to_q16(input longint v);
        longint r;
        r = (v + ROUND_HALF_Q30) >>> 14;
        if (r > UNIT_Q16) r = UNIT_Q16;
        if (r < -UNIT_Q16) r = -UNIT_Q16;
        return r;
    endfunction

    // Exact modulo-360 reduction, quadrant split, CORDIC rotation and mapping.
    function automatic trig_pair_t predict_trig(input logic [DSC_ANGLE_W-1:0] angle);
        longint     ang, red, quad, z, x, y, dx, dy, s, c, so, co;
        logic [1:0] quad_code;
        trig_pair_t res;
        ang = longint'($signed(angle));
        red = ang % FULL_TURN_Q16;
        if (red < 0) red += FULL_TURN_Q16;
        quad = red / QUARTER_TURN_Q16;
        z = (red - quad * QUARTER_TURN_Q16) * 256;
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < ROTATION_STEPS && i < ATAN_COUNT; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ATAN_DEG_Q24[i];
            end else begin
                x += dx;
                y -= dy;
                z += ATAN_DEG_Q24[i];
            end
        end
        s = round_to_q16(y);
        c = round_to_q16(x);
        quad_code = quad[1:0];
        case (quad_code)
            DSC_QUAD_0: begin so = s;  co = c;  end
            DSC_QUAD_1: begin so = c;  co = -s; end
            DSC_QUAD_2: begin so = -s; co = -c; end
            default:    begin so = -c; co = s;  end
        endcase
        res.sine   = so[DSC_OUT_W-1:0];
        res.cosine = co[DSC_OUT_W-1:0];
        return res;
    endfunction

    // Predict on each accepted angle, compare on each accepted result item.
    always @(posedge i_clk) begin
        trig_pair_t want;
        trig_pair_t got;
        int         errs;
        errs = 0;
        if (!i_rst_n) begin
            trig_expected_q.delete();
            o_fail_count    <= 0;
            o_pending_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                trig_expected_q.push_back(predict_trig(i_s_tdata[DSC_ANGLE_W-1:0]));
            if (i_m_tvalid && i_m_tready) begin
                got.sine   = i_m_tdata[DSC_OUT_W-1:0];
                got.cosine = i_m_tdata[2*DSC_OUT_W-1:DSC_OUT_W];
                if (trig_expected_q.size() == 0) begin
                    $error("unexpected result item: sine %0d, cosine %0d",
                           got.sine, got.cosine);
                    errs++;
                end else begin
                    want = trig_expected_q.pop_front();
                    if (got.sine !== want.sine) begin
                        $error("sine mismatch: expected %0d, actual %0d",
                               want.sine, got.sine);
                        errs++;
                    end
                    if (got.cosine !== want.cosine) begin
                        $error("cosine mismatch: expected %0d, actual %0d",
                               want.cosine, got.cosine);
                        errs++;
                    end
                    // The four bits above the two fields must all be zero.
                    if (i_m_tdata[DSC_OUT_TDATA_W-1:2*DSC_OUT_W] !== '0) begin
                        $error("pad mismatch: expected 0, actual %0d",
                               i_m_tdata[DSC_OUT_TDATA_W-1:2*DSC_OUT_W]);
                        errs++;
                    end
                end
            end
            o_fail_count    <= o_fail_count + errs;
            o_pending_count <= trig_expected_q.size();
        end
    end

endmodule

/* tb/sv/tb_degree_sine_cosine.sv */
// ----------------------------------------------------------------------------
// tb_degree_sine_cosine
// Drives angles into the degree sine/cosine block with random gaps on both
// channels; a checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_degree_sine_cosine
    import dsc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROTATION_STEPS = DSC_STEPS_DEFAULT;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 1880;
    localparam int IDLE_PERCENT   = 17;
    localparam int STEADY_FIRST   = 900;
    localparam int STEADY_LAST    = 1200;
    localparam int DRAIN_CYCLES   = ROTATION_STEPS + 6 + 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TURN_Q16       = 23592960;
    localparam int QUARTER_Q16    = 5898240;

    // Quadrant edges, 30/45/60 degrees, full-range extremes, whole turns and near-boundary angles.
    localparam logic [31:0] DIRECTED_ANGLES [22] = '{
        32'd0, 32'd5898240, 32'd11796480, 32'd17694720, 32'd23592960,
        -32'sd5898240, -32'sd11796480, 32'd2949120, 32'd1966080, 32'd3932160,
        32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1,
        32'd5898239, 32'd5898241, 32'd23592959, -32'sd23592960,
        32'd47185920, 32'd2146959360, -32'sd2146959360, 32'd17694719
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [DSC_IN_TDATA_W-1:0]  s_tdata = '0;   // [31:0] angle_deg
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [DSC_OUT_TDATA_W-1:0] m_tdata;        // [17:0] sine, [35:18] cosine
    logic        steady = 1'b0;
    int          fail_count;
    int          pending_count;
    int          quiet_cycles = 0;

    degree_sine_cosine #(
        .ROTATION_STEPS(ROTATION_STEPS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    degree_sine_cosine_checker #(
        .ROTATION_STEPS(ROTATION_STEPS)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // The receiver stalls at random except during the steady stretch.
    always @(posedge clk) begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Ends the run if neither channel moves an item for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Full-range angles, angles within one turn either way, quadrant edges and near zero.
    function automatic logic [31:0] random_angle();
        int unsigned pick;
        int          k;
        pick = $urandom_range(99);
        if (pick < 40) begin
            return $urandom;
        end else if (pick < 70) begin
            return $urandom_range(2 * TURN_Q16) - TURN_Q16;
        end else if (pick < 90) begin
            k = int'($urandom_range(720)) - 360;
            return k * QUARTER_Q16 + int'($urandom_range(64)) - 32;
        end else begin
            return int'($urandom_range(1023)) - 512;
        end
    endfunction

    // Offers one angle, after an optional random gap, and waits for acceptance.
    task automatic send_angle(input logic [31:0] angle);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= angle;
        do @(posedge clk); while (!s_tready);
    endtask

    initial begin
        int n;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ANGLES[k]) send_angle(DIRECTED_ANGLES[k]);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == STEADY_FIRST) steady <= 1'b1;
            if (n == STEADY_LAST) steady <= 1'b0;
            send_angle(random_angle());
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        // Let the pipeline empty, then give stray items a chance to show up.
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
